### rtl/bchd_pkg.sv
`timescale 1ns / 1ps

package bchd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd90;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd900;
  localparam logic [CFG_W-1:0] LOCKOUT_RST  = 16'd250;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_LOCKOUT  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_HOLD  = 2'd2
  } ev_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] hold_time;
    logic [CFG_W-1:0] lockout_time;
  } cfg_t;

  typedef struct packed {
    logic              last_raw;
    logic              debounced;
    logic [TIME_W-1:0] raw_change_time;
    logic              press_active;
    logic [TIME_W-1:0] press_start_time;
    logic [TIME_W-1:0] last_report_time;
    logic              hold_reported;
  } btn_state_t;

endpackage

### rtl/bchd_core.sv
`timescale 1ns / 1ps

module bchd_core import bchd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              raw_level,
  input  logic [TIME_W-1:0] now_ms,
  input  cfg_t              cfg,
  output ev_t               event_code,
  output logic              stable_level,
  output logic              press_active
);

  btn_state_t        st_r;
  btn_state_t        st_nxt;
  logic [TIME_W-1:0] el_raw;
  logic [TIME_W-1:0] el_press;
  logic [TIME_W-1:0] el_report;
  logic              debounce_ok;
  logic              hold_due;
  logic              lockout_ok;
  ev_t               ev;

  // Wrapping elapsed times
  assign el_raw    = now_ms - st_r.raw_change_time;
  assign el_press  = now_ms - st_r.press_start_time;
  assign el_report = now_ms - st_r.last_report_time;

  assign debounce_ok = el_raw    >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time};
  assign hold_due    = el_press  >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_time};
  assign lockout_ok  = el_report >= {{(TIME_W-CFG_W){1'b0}}, cfg.lockout_time};

  always_comb begin
    st_nxt = st_r;
    ev     = EV_NONE;
    if (raw_level != st_r.last_raw) begin
      st_nxt.last_raw        = raw_level;
      st_nxt.raw_change_time = now_ms;
    end else if (debounce_ok) begin
      if (raw_level == st_r.debounced) begin
        if (st_r.press_active && !st_r.hold_reported && hold_due && lockout_ok) begin
          st_nxt.hold_reported    = 1'b1;
          st_nxt.last_report_time = now_ms;
          ev                      = EV_HOLD;
        end
      end else begin
        st_nxt.debounced = raw_level;
        if (!raw_level) begin
          st_nxt.press_active     = 1'b1;
          st_nxt.press_start_time = now_ms;
          st_nxt.hold_reported    = 1'b0;
        end else if (st_r.press_active) begin
          // a release inside the lockout drops the click
          if (!st_r.hold_reported && !hold_due && lockout_ok) begin
            st_nxt.last_report_time = now_ms;
            ev                      = EV_CLICK;
          end
          st_nxt.press_active  = 1'b0;
          st_nxt.hold_reported = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.last_raw         <= 1'b1;
      st_r.debounced        <= 1'b1;
      st_r.raw_change_time  <= '0;
      st_r.press_active     <= 1'b0;
      st_r.press_start_time <= '0;
      st_r.last_report_time <= '0;
      st_r.hold_reported    <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign event_code   = ev;
  assign stable_level = st_nxt.debounced;
  assign press_active = st_r.press_active;

endmodule

### rtl/button_click_hold_detector.sv
`timescale 1ns / 1ps

// Debounces one active-low push button polled with a millisecond timestamp
// and reports at most one click or hold per press. Every accepted poll yields exactly
// one result (event code plus debounced level). A poll can be accepted on
// every clock unless output backpressure stalls it; the poll waits in the
// input register until the result register is free or being taken, and then
// the single compute stage (three 32-bit wrapping subtractions and compares
// against the timing registers) loads the result register, whose content is
// offered on the output. The output register lets the next poll enter while
// a result still waits to be taken. Write timing registers only while idle.
module button_click_hold_detector import bchd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_raw_level,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_code,
  output logic              out_stable_level,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t              cfg_r;
  logic              in_valid_r;
  logic              in_raw_r;
  logic [TIME_W-1:0] in_now_r;
  logic              out_valid_r;
  ev_t               out_event_r;
  logic              out_stable_r;
  logic              advance;
  ev_t               core_event;
  logic              core_stable;
  logic              press_active;

  // Move the held transaction into the result register
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time <= DEBOUNCE_RST;
      cfg_r.hold_time     <= HOLD_RST;
      cfg_r.lockout_time  <= LOCKOUT_RST;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: cfg_r.debounce_time <= cfg_wdata;
        REG_HOLD:     cfg_r.hold_time     <= cfg_wdata;
        REG_LOCKOUT:  cfg_r.lockout_time  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_raw_r <= in_raw_level;
      in_now_r <= in_now_ms;
    end
  end

  bchd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .raw_level    (in_raw_r),
    .now_ms       (in_now_r),
    .cfg          (cfg_r),
    .event_code   (core_event),
    .stable_level (core_stable),
    .press_active (press_active)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r  <= core_event;
      out_stable_r <= core_stable;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_code   = out_event_r;
  assign out_stable_level = out_stable_r;

`ifndef SYNTHESIS
  a_hold_while_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == EV_HOLD) |-> !out_stable_r)
    else $error("hold reported while debounced level is released");

  a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == EV_CLICK) |-> out_stable_r)
    else $error("click reported while debounced level is pressed");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without output backpressure");

  a_press_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (press_active && out_valid_r && $past(advance)) |-> !out_stable_r)
    else $error("press active while debounced level is released");
`endif

endmodule
